// File: src/bhx_pkg.sv
// Package: shared types, code constants and decode functions for the BinHex text decoder.
`timescale 1ns / 1ps

package bhx_pkg;

	// Run-length mark and character class codes
	localparam logic [7:0] RUN_MARK     = 8'h90;
	localparam logic [7:0] CODE_BLANK   = 8'hFC;
	localparam logic [7:0] CODE_COLON   = 8'hFD;
	localparam logic [7:0] CODE_NEWLINE = 8'hFE;
	localparam logic [7:0] CODE_BAD     = 8'hFF;

	// Raw characters with a meaning of their own
	localparam logic [7:0] CH_TAB   = 8'h09;
	localparam logic [7:0] CH_LF    = 8'h0A;
	localparam logic [7:0] CH_CR    = 8'h0D;
	localparam logic [7:0] CH_SPACE = 8'h20;
	localparam logic [7:0] CH_COLON = 8'h3A;

	// The 64-symbol alphabet, first symbol in the top byte
	localparam int ALPHA_LEN = 64;
	localparam logic [8*ALPHA_LEN-1:0] ALPHABET = {
		"!\"#$%&'()*+,-012345689@ABCDEFGHIJKLMNPQRSTUVXYZ[", 8'h60,
		"abcdefhijklmpqr"
	};

	// Most results one character can cause
	localparam int RESULTS_MAX = 3;

	// Result queue entries; pointers wrap, so a power of two
	localparam int QUEUE_DEPTH = 8;

	typedef logic [5:0] sextet_t;

	typedef struct packed {
		logic [7:0] data_byte;
		logic [7:0] repeat_count;
		logic       last_of_input;
		logic       end_of_stream;
	} result_t;

	// Up to three results written into the queue in one cycle
	typedef struct packed {
		logic [RESULTS_MAX-1:0] vld;
		result_t [RESULTS_MAX-1:0] item;
	} push_t;

	// One step of the run-length expander
	typedef struct packed {
		logic       emit;
		logic [7:0] value;
		logic [7:0] rep;
		logic       run;
		logic [7:0] last;
	} exp_t;

	// Map a raw character to its 6-bit value or a class code
	function automatic logic [7:0] classify(input logic [7:0] ch);
		logic [7:0] code;
		code = CODE_BAD;
		for (int k = 0; k < ALPHA_LEN; k++) begin
			if (ALPHABET[8*(ALPHA_LEN-1-k) +: 8] == ch) code = 8'(k);
		end
		if (ch == CH_LF || ch == CH_CR) code = CODE_NEWLINE;
		if (ch == CH_SPACE || ch == CH_TAB) code = CODE_BLANK;
		if (ch == CH_COLON) code = CODE_COLON;
		return code;
	endfunction

	// Feed one decoded byte through the 0x90 expander
	function automatic exp_t expand(input logic run, input logic [7:0] last,
		input logic [7:0] b);
		exp_t r;
		r.emit  = 1'b0;
		r.value = b;
		r.rep   = 8'd1;
		r.run   = 1'b0;
		r.last  = last;
		if (run) begin
			if (b == 8'd0) begin
				// escaped literal mark
				r.emit  = 1'b1;
				r.value = RUN_MARK;
				r.last  = RUN_MARK;
			end else if (b != 8'd1) begin
				// repeat the last byte count-1 times
				r.emit  = 1'b1;
				r.value = last;
				r.rep   = b - 8'd1;
			end
		end else begin
			r.run = (b == RUN_MARK);
			if (b != RUN_MARK) begin
				r.emit = 1'b1;
				r.last = b;
			end
		end
		return r;
	endfunction

endpackage

// File: src/bhx_if.sv
// Interfaces: character input channel and decoded result channel.
`timescale 1ns / 1ps

interface bhx_in_if;
	logic       valid;
	logic       ready;
	logic [7:0] char_code;
	logic       start_stream;

	modport source (output valid, char_code, start_stream, input ready);
	modport sink (input valid, char_code, start_stream, output ready);
endinterface

interface bhx_out_if;
	logic       valid;
	logic       ready;
	logic [7:0] data_byte;
	logic [7:0] repeat_count;
	logic       last_of_input;
	logic       end_of_stream;

	modport source (output valid, data_byte, repeat_count, last_of_input, end_of_stream,
		input ready);
	modport sink (input valid, data_byte, repeat_count, last_of_input, end_of_stream,
		output ready);
endinterface

// File: src/bhx_decode.sv
// Decode stage: character classing, sextet grouping, run-length expansion and stream state.
`timescale 1ns / 1ps

module bhx_decode import bhx_pkg::*; (
	input  logic       clk,
	input  logic       arst_n,
	input  logic       fire,
	input  logic [7:0] char_code,
	input  logic       start_stream,
	output push_t      push
);

	sextet_t [2:0] grp_q, grp_e, grp_n, grp_m;
	logic [1:0]    fill_q, fill_e, fill_n;
	logic          run_q, run_e, run_n;
	logic [7:0]    last_q, last_e, last_n;
	logic          brk_q, brk_e, brk_n;
	logic          done_q, done_e, done_n;

	logic [7:0]    code;
	logic          do_dec;
	logic          term;
	sextet_t       tail;
	logic [7:0]    b0, b1, b2;
	exp_t          x0, x1, x2;

	// Next state and results for the character in the input register
	always_comb begin
		// a start beat sees reset state
		grp_e  = start_stream ? '0 : grp_q;
		fill_e = start_stream ? '0 : fill_q;
		run_e  = start_stream ? 1'b0 : run_q;
		last_e = start_stream ? '0 : last_q;
		brk_e  = start_stream ? 1'b0 : brk_q;
		done_e = start_stream ? 1'b0 : done_q;

		grp_n  = grp_e;
		fill_n = fill_e;
		run_n  = run_e;
		last_n = last_e;
		brk_n  = brk_e;
		done_n = done_e;

		code   = classify(char_code);
		do_dec = 1'b0;
		term   = 1'b0;
		tail   = '0;

		if (!done_e) begin
			priority if (code == CODE_NEWLINE) begin
				brk_n = 1'b1;
			end else if (code == CODE_BLANK && brk_e) begin
				// blank after a line break: skipped
			end else if (code == CODE_BLANK || code == CODE_COLON || code == CODE_BAD) begin
				term   = 1'b1;
				do_dec = 1'b1;
			end else begin
				brk_n = 1'b0;
				if (fill_e != 2'd3) begin
					grp_n[fill_e] = code[5:0];
					fill_n        = fill_e + 2'd1;
				end else begin
					do_dec = 1'b1;
					tail   = code[5:0];
				end
			end
		end

		// zero-pad the slots not yet filled
		for (int k = 0; k < 3; k++) begin
			grp_m[k] = (2'(k) < fill_e) ? grp_e[k] : '0;
		end

		b0 = {grp_m[0], grp_m[1][5:4]};
		b1 = {grp_m[1][3:0], grp_m[2][5:2]};
		b2 = {grp_m[2][1:0], tail};

		// three expander steps in a row
		x0 = expand(run_e, last_e, b0);
		x1 = expand(x0.run, x0.last, b1);
		x2 = expand(x1.run, x1.last, b2);

		push.vld  = '0;
		push.item = '0;
		push.item[0] = '{data_byte: x0.value, repeat_count: x0.rep,
			last_of_input: 1'b0, end_of_stream: 1'b0};
		push.item[1] = '{data_byte: x1.value, repeat_count: x1.rep,
			last_of_input: 1'b0, end_of_stream: 1'b0};
		push.item[2] = '{data_byte: x2.value, repeat_count: x2.rep,
			last_of_input: 1'b0, end_of_stream: 1'b0};

		if (do_dec) begin
			push.vld = {x2.emit, x1.emit, x0.emit} & {RESULTS_MAX{fire}};
			run_n    = x2.run;
			last_n   = x2.last;
			grp_n    = '0;
			fill_n   = '0;
			done_n   = term;
			// mark the final result of this character
			priority if (x2.emit) begin
				push.item[2].last_of_input = 1'b1;
				push.item[2].end_of_stream = term;
			end else if (x1.emit) begin
				push.item[1].last_of_input = 1'b1;
				push.item[1].end_of_stream = term;
			end else begin
				push.item[0].last_of_input = 1'b1;
				push.item[0].end_of_stream = term;
			end
		end
	end

	// Stream state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			grp_q  <= '0;
			fill_q <= '0;
			run_q  <= 1'b0;
			last_q <= '0;
			brk_q  <= 1'b0;
			done_q <= 1'b0;
		end else if (fire) begin
			grp_q  <= grp_n;
			fill_q <= fill_n;
			run_q  <= run_n;
			last_q <= last_n;
			brk_q  <= brk_n;
			done_q <= done_n;
		end
	end

	// A terminator closes the stream
	a_term_done: assert property (@(posedge clk) disable iff (!arst_n)
		fire && term |=> done_q)
		else $error("terminator did not close the stream");

	// A closed stream yields nothing until restarted
	a_done_quiet: assert property (@(posedge clk) disable iff (!arst_n)
		done_q && !start_stream |-> push.vld == '0)
		else $error("result after end of stream");

endmodule

// File: src/bhx_queue.sv
// Result queue: takes up to three results a cycle, hands out one per beat.
`timescale 1ns / 1ps

module bhx_queue import bhx_pkg::*; (
	input  logic        clk,
	input  logic        arst_n,
	input  push_t       push,
	output logic        room,
	bhx_out_if.source   bytes
);

	localparam int PW = $clog2(QUEUE_DEPTH);
	localparam int CW = PW + 1;

	result_t        mem_q [QUEUE_DEPTH];
	logic [PW-1:0]  wr_q, rd_q;
	logic [CW-1:0]  cnt_q;
	logic           pop;
	logic [1:0]     npush;
	logic [PW-1:0]  off;
	logic [PW-1:0]  slot [RESULTS_MAX];

	// Room for a full set of results from one character
	assign room = cnt_q <= CW'(QUEUE_DEPTH - RESULTS_MAX);

	assign bytes.valid         = cnt_q != '0;
	assign bytes.data_byte     = mem_q[rd_q].data_byte;
	assign bytes.repeat_count  = mem_q[rd_q].repeat_count;
	assign bytes.last_of_input = mem_q[rd_q].last_of_input;
	assign bytes.end_of_stream = mem_q[rd_q].end_of_stream;
	assign pop                 = bytes.valid && bytes.ready;

	// Pack the valid results into consecutive slots
	always_comb begin
		off = '0;
		for (int i = 0; i < RESULTS_MAX; i++) begin
			slot[i] = wr_q + off;
			off     = off + PW'(push.vld[i]);
		end
		npush = 2'(push.vld[0]) + 2'(push.vld[1]) + 2'(push.vld[2]);
	end

	// Storage
	always_ff @(posedge clk) begin
		for (int i = 0; i < RESULTS_MAX; i++) begin
			if (push.vld[i]) mem_q[slot[i]] <= push.item[i];
		end
	end

	// Pointers and fill count
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_q  <= '0;
			rd_q  <= '0;
			cnt_q <= '0;
		end else begin
			wr_q  <= wr_q + PW'(npush);
			rd_q  <= rd_q + PW'(pop);
			cnt_q <= cnt_q + CW'(npush) - CW'(pop);
		end
	end

	a_no_overflow: assert property (@(posedge clk) disable iff (!arst_n)
		cnt_q <= CW'(QUEUE_DEPTH))
		else $error("result queue overflow");

	a_push_room: assert property (@(posedge clk) disable iff (!arst_n)
		push.vld != '0 |-> room)
		else $error("results pushed without room");

endmodule

// File: src/binhex_text_decoder.sv
// Top level: BinHex 4.0 text decoder with input register and result queue.
`timescale 1ns / 1ps
//
// Usage
//   text  : one encoded character per beat (char_code), with start_stream set on
//           the first character of a new stream to clear all decoder state.
//   bytes : decoded results, one per beat. Each result is data_byte emitted
//           repeat_count times; last_of_input marks the final result of a
//           character, end_of_stream the final result after a terminator.
//   A character yields zero to three results. Characters after a terminator
//   yield none until start_stream is seen.
// Timing
//   A character is registered in the input register on acceptance and, once
//   the queue has room, decoded from that register straight into the result
//   queue. One character per cycle is taken while the queue has room for
//   three more results. Results leave at one per cycle while bytes.ready is
//   high; data gives three results per four characters, so a ready receiver
//   never stalls the input, while back-to-back terminators (three results
//   each) are paced by the output port.
// Stall and reset
//   When bytes.ready is low the queue fills, the input register holds and
//   text.ready drops. Reset empties the queue and clears the stream state.

module binhex_text_decoder import bhx_pkg::*; (
	input  logic      clk,
	input  logic      arst_n,
	bhx_in_if.sink    text,
	bhx_out_if.source bytes
);

	logic       vld_s1;
	logic [7:0] char_s1;
	logic       start_s1;
	logic       room;
	logic       fire;
	push_t      push;

	assign fire       = vld_s1 && room;
	assign text.ready = !vld_s1 || room;

	// Input register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1 <= 1'b0;
		end else if (text.ready) begin
			vld_s1 <= text.valid;
		end
	end

	always_ff @(posedge clk) begin
		if (text.ready) begin
			char_s1  <= text.char_code;
			start_s1 <= text.start_stream;
		end
	end

	bhx_decode u_decode (
		.clk          (clk),
		.arst_n       (arst_n),
		.fire         (fire),
		.char_code    (char_s1),
		.start_stream (start_s1),
		.push         (push)
	);

	bhx_queue u_queue (
		.clk    (clk),
		.arst_n (arst_n),
		.push   (push),
		.room   (room),
		.bytes  (bytes)
	);

	// A held character stays put until the queue frees room
	a_s1_hold: assert property (@(posedge clk) disable iff (!arst_n)
		vld_s1 && !room |=> vld_s1 && $stable(char_s1) && $stable(start_s1))
		else $error("input register lost a waiting character");

endmodule

// File: dv/binhex_text_decoder_test.sv
// Testbench for the BinHex text decoder: directed and random streams against a predictor.
`timescale 1ns / 1ps

module binhex_text_decoder_test;
	import bhx_pkg::*;

	localparam int CYCLE_LIMIT  = 200000;
	localparam int DRAIN_CYCLES = 16;
	localparam int MAX_REPORTS  = 10;

	// Receiver stall behavior, one mode at a time, each picked at random
	typedef enum logic [1:0] {RX_FREE, RX_LIGHT, RX_HEAVY, RX_BLOCKS} rx_mode_t;

	logic clk = 1'b0;
	logic arst_n = 1'b0;

	bhx_in_if  text_ch ();
	bhx_out_if byte_ch ();

	binhex_text_decoder dut (
		.clk    (clk),
		.arst_n (arst_n),
		.text   (text_ch),
		.bytes  (byte_ch)
	);

	always #1 clk = ~clk;

	// Character lookup: sextet -> character and character -> sextet or class code
	logic [7:0] sextet_char [64];
	logic [7:0] char_class [256];

	// Decoder state as predicted
	sextet_t    grp [3];
	int         grp_fill;
	bit         run_open;
	logic [7:0] last_byte;
	bit         after_break;
	bit         stream_over;

	// Results of the character being predicted, then the bytes still awaited
	logic [7:0] fresh_byte [3];
	logic [7:0] fresh_rep [3];
	int         fresh_n;
	result_t    expected_bytes [$];

	logic [7:0] payload [$];
	int         chars_used;
	int         burst_left;
	int         mismatches;
	int         cycles;

	task automatic build_tables();
		string head, tail;
		int k;
		head = "!\"#$%&'()*+,-012345689@ABCDEFGHIJKLMNPQRSTUVXYZ[";
		tail = "abcdefhijklmpqr";
		for (k = 0; k < 48; k++) sextet_char[k] = head[k];
		sextet_char[48] = 8'h60;
		for (k = 0; k < 15; k++) sextet_char[49 + k] = tail[k];
		for (k = 0; k < 256; k++) char_class[k] = CODE_BAD;
		for (k = 0; k < 64; k++) char_class[sextet_char[k]] = 8'(k);
		char_class[CH_LF]    = CODE_NEWLINE;
		char_class[CH_CR]    = CODE_NEWLINE;
		char_class[CH_SPACE] = CODE_BLANK;
		char_class[CH_TAB]   = CODE_BLANK;
		char_class[CH_COLON] = CODE_COLON;
	endtask

	task automatic clear_stream();
		int k;
		for (k = 0; k < 3; k++) grp[k] = '0;
		grp_fill    = 0;
		run_open    = 1'b0;
		last_byte   = 8'h00;
		after_break = 1'b0;
		stream_over = 1'b0;
	endtask

	task automatic add_byte(input logic [7:0] b, input logic [7:0] rep);
		fresh_byte[fresh_n] = b;
		fresh_rep[fresh_n]  = rep;
		fresh_n++;
	endtask

	// 0x90 run-length expansion of one decoded byte
	task automatic expand_byte(input logic [7:0] b);
		if (run_open) begin
			// count byte never opens a new run
			run_open = 1'b0;
			if (b == 8'h00) begin
				add_byte(RUN_MARK, 8'd1);
				last_byte = RUN_MARK;
			end else if (b != 8'h01) begin
				add_byte(last_byte, b - 8'd1);
			end
		end else begin
			run_open = (b == RUN_MARK);
			if (!run_open) begin
				add_byte(b, 8'd1);
				last_byte = b;
			end
		end
	endtask

	// Four sextets, most significant first, give three bytes
	task automatic unpack_group(input sextet_t s3);
		int k;
		expand_byte({grp[0], grp[1][5:4]});
		expand_byte({grp[1][3:0], grp[2][5:2]});
		expand_byte({grp[2][1:0], s3});
		for (k = 0; k < 3; k++) grp[k] = '0;
		grp_fill = 0;
	endtask

	// Predict the bytes one accepted character causes
	task automatic decode_char(input logic [7:0] ch, input logic st);
		logic [7:0] code;
		bit closing;
		result_t r;
		int k;
		code    = char_class[ch];
		fresh_n = 0;
		if (st) clear_stream();
		if (stream_over) return;
		if (code == CODE_NEWLINE) begin
			after_break = 1'b1;
			return;
		end
		// blank right after a line break is skipped
		if (code == CODE_BLANK && after_break) return;
		closing = (code == CODE_BLANK || code == CODE_COLON || code == CODE_BAD);
		if (closing) begin
			// zero-pad the partial group and flush it
			for (k = grp_fill; k < 3; k++) grp[k] = '0;
			unpack_group('0);
			stream_over = 1'b1;
		end else begin
			after_break = 1'b0;
			if (grp_fill < 3) begin
				grp[grp_fill] = code[5:0];
				grp_fill++;
			end else begin
				unpack_group(code[5:0]);
			end
		end
		for (k = 0; k < fresh_n; k++) begin
			r.data_byte     = fresh_byte[k];
			r.repeat_count  = fresh_rep[k];
			r.last_of_input = (k == fresh_n - 1);
			r.end_of_stream = closing && (k == fresh_n - 1);
			expected_bytes.push_back(r);
		end
	endtask

	// Send one character in bursts with random gaps; predict on acceptance
	task automatic send_char(input logic [7:0] ch, input logic st);
		int gap;
		if (burst_left == 0) begin
			burst_left = $urandom_range(1, 16);
			gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 5);
			if (gap > 0) begin
				text_ch.valid <= 1'b0;
				repeat (gap) @(posedge clk);
			end
		end
		burst_left--;
		text_ch.valid        <= 1'b1;
		text_ch.char_code    <= ch;
		text_ch.start_stream <= st;
		@(posedge clk);
		while (!text_ch.ready) @(posedge clk);
		decode_char(ch, st);
		chars_used++;
	endtask

	// Hold off the sender until every expected byte has come out
	task automatic wait_drained();
		text_ch.valid <= 1'b0;
		burst_left = 0;
		@(posedge clk);
		while (expected_bytes.size() != 0) @(posedge clk);
		repeat (4) @(posedge clk);
	endtask

	// Encode the payload bytes as characters, with optional line breaks
	task automatic send_payload(input bit fresh, input int break_pct);
		sextet_t sx [4];
		logic [7:0] b0, b1, b2;
		int i, j, n, nsx;
		bit first;
		n = payload.size();
		first = fresh;
		for (i = 0; i < n; i += 3) begin
			b0  = payload[i];
			b1  = (i + 1 < n) ? payload[i + 1] : 8'h00;
			b2  = (i + 2 < n) ? payload[i + 2] : 8'h00;
			nsx = (n - i >= 3) ? 4 : n - i + 1;
			sx[0] = b0[7:2];
			sx[1] = {b0[1:0], b1[7:4]};
			sx[2] = {b1[3:0], b2[7:6]};
			sx[3] = b2[5:0];
			for (j = 0; j < nsx; j++) begin
				if (!first && $urandom_range(0, 99) < break_pct) begin
					send_char($urandom_range(0, 1) ? CH_LF : CH_CR, 1'b0);
					repeat ($urandom_range(0, 2))
						send_char($urandom_range(0, 1) ? CH_SPACE : CH_TAB, 1'b0);
				end
				send_char(sextet_char[sx[j]], first);
				first = 1'b0;
			end
		end
	endtask

	task automatic end_stream();
		logic [7:0] ch;
		case ($urandom_range(0, 3))
			0: ch = CH_COLON;
			1: ch = CH_SPACE;
			2: ch = CH_TAB;
			default: begin
				ch = 8'($urandom_range(0, 255));
				while (char_class[ch] != CODE_BAD) ch = 8'($urandom_range(0, 255));
			end
		endcase
		send_char(ch, 1'b0);
	endtask

	// Payload byte, biased toward run marks and their counts
	function automatic logic [7:0] pick_byte();
		case ($urandom_range(0, 9))
			0, 1: return RUN_MARK;
			2: return $urandom_range(0, 1) ? 8'h00 : 8'hFF;
			3: return 8'($urandom_range(0, 2));
			default: return 8'($urandom_range(0, 255));
		endcase
	endfunction

	task automatic test_alphabet_extremes();
		send_char(sextet_char[0], 1'b1);
		send_char(sextet_char[63], 1'b0);
		send_char(sextet_char[0], 1'b0);
		send_char(sextet_char[63], 1'b0);
	endtask

	// Escaped mark, longest run, and a count of one
	task automatic test_run_length();
		payload = '{RUN_MARK, 8'h00, RUN_MARK, 8'hFF, RUN_MARK, 8'h01};
		send_payload(1'b0, 0);
	endtask

	task automatic test_line_breaks();
		send_char(CH_LF, 1'b0);
		send_char(CH_SPACE, 1'b0);
		send_char(CH_TAB, 1'b0);
		send_char(CH_CR, 1'b0);
		send_char(sextet_char[63], 1'b0);
	endtask

	task automatic test_terminators();
		// blank after data ends the stream, later characters are dropped
		send_char(CH_SPACE, 1'b0);
		send_char(CH_COLON, 1'b0);
		// terminator on an empty group still flushes three zero bytes
		send_char(CH_COLON, 1'b1);
		send_char(8'hFF, 1'b1);
		send_char(8'h00, 1'b1);
		send_char(8'h7F, 1'b1);
	endtask

	// Well-formed streams with random content, trailing junk after the end
	task automatic test_random_streams(input int goal);
		int len, k;
		goal += chars_used;
		while (chars_used < goal) begin
			len = ($urandom_range(0, 3) == 0) ? $urandom_range(13, 40) : $urandom_range(1, 12);
			payload.delete();
			for (k = 0; k < len; k++) payload.push_back(pick_byte());
			send_payload(1'b1, 15);
			end_stream();
			repeat ($urandom_range(0, 2)) send_char(8'($urandom_range(0, 255)), 1'b0);
		end
	endtask

	// Loose characters and stray restarts
	task automatic test_noise(input int goal);
		logic [7:0] ch;
		int r;
		goal += chars_used;
		while (chars_used < goal) begin
			r = $urandom_range(0, 19);
			if (r < 14) ch = sextet_char[6'($urandom_range(0, 63))];
			else if (r < 17) begin
				case ($urandom_range(0, 3))
					0: ch = CH_LF;
					1: ch = CH_CR;
					2: ch = CH_SPACE;
					default: ch = CH_TAB;
				endcase
			end else ch = 8'($urandom_range(0, 255));
			send_char(ch, $urandom_range(0, 7) == 0);
		end
	endtask

	task automatic log_mismatch(input string what, input result_t want, input result_t got);
		mismatches++;
		if (mismatches <= MAX_REPORTS)
			$display("%0t %s: expected byte %02h x%0d last %b end %b, %s",
				$realtime, what, want.data_byte, want.repeat_count, want.last_of_input,
				want.end_of_stream,
				$sformatf("got byte %02h x%0d last %b end %b",
					got.data_byte, got.repeat_count, got.last_of_input,
					got.end_of_stream));
	endtask

	// Result checker: every accepted beat against the oldest expectation
	always @(posedge clk) begin : check_bytes
		result_t got, want;
		if (arst_n && byte_ch.valid && byte_ch.ready) begin
			got.data_byte     = byte_ch.data_byte;
			got.repeat_count  = byte_ch.repeat_count;
			got.last_of_input = byte_ch.last_of_input;
			got.end_of_stream = byte_ch.end_of_stream;
			if (expected_bytes.size() == 0) begin
				log_mismatch("unexpected beat", '0, got);
			end else begin
				want = expected_bytes.pop_front();
				if (got.data_byte !== want.data_byte || got.repeat_count !== want.repeat_count
					|| got.last_of_input !== want.last_of_input
					|| got.end_of_stream !== want.end_of_stream)
					log_mismatch("wrong beat", want, got);
			end
		end
	end

	// Receiver ready pattern
	initial begin : drive_ready
		rx_mode_t mode;
		int mode_left;
		mode_left = 0;
		mode = RX_FREE;
		byte_ch.ready <= 1'b0;
		forever begin
			@(posedge clk);
			if (mode_left == 0) begin
				mode = rx_mode_t'($urandom_range(0, 3));
				mode_left = $urandom_range(20, 120);
			end
			mode_left--;
			case (mode)
				RX_FREE:  byte_ch.ready <= 1'b1;
				RX_LIGHT: byte_ch.ready <= ($urandom_range(0, 3) != 0);
				RX_HEAVY: byte_ch.ready <= ($urandom_range(0, 3) == 0);
				default:  byte_ch.ready <= ((mode_left % 16) < 6);
			endcase
		end
	end

	// Watchdog
	always @(posedge clk) begin
		cycles++;
		if (cycles >= CYCLE_LIMIT) begin
			$display("CHECK FAILED");
			$finish;
		end
	end

	initial begin
		cycles     = 0;
		mismatches = 0;
		chars_used = 0;
		burst_left = 0;
		build_tables();
		clear_stream();
		text_ch.valid        <= 1'b0;
		text_ch.char_code    <= 8'h00;
		text_ch.start_stream <= 1'b0;
		repeat (9) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		test_alphabet_extremes();
		test_run_length();
		test_line_breaks();
		test_terminators();
		wait_drained();
		test_random_streams(230);
		wait_drained();
		test_noise(60);
		wait_drained();

		repeat (DRAIN_CYCLES) @(posedge clk);
		mismatches += expected_bytes.size();
		if (mismatches == 0) begin
			$display("CHECK OK");
		end else begin
			$display("CHECK FAILED");
		end
		$finish;
	end

endmodule

// File: files.f
src/bhx_pkg.sv
src/bhx_if.sv
src/bhx_decode.sv
src/bhx_queue.sv
src/binhex_text_decoder.sv
dv/binhex_text_decoder_test.sv
